/* design/rcmm_pkg.sv */
// Shared types, register indexes and default sizes for the RGB convolution block.
`default_nettype none
package rcmm_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;
  localparam int DEF_MAX_RADIUS = 2;

  localparam int COEF_COUNT = 25;
  localparam int COEF_BITS  = COEF_COUNT * 8;

  localparam logic [2:0] CFG_WIDTH  = 3'd0;
  localparam logic [2:0] CFG_HEIGHT = 3'd1;
  localparam logic [2:0] CFG_RADIUS = 3'd2;
  localparam logic [2:0] CFG_COEF0  = 3'd3;
  localparam logic [2:0] CFG_COEF1  = 3'd4;
  localparam logic [2:0] CFG_COEF2  = 3'd5;
  localparam logic [2:0] CFG_COEF3  = 3'd6;

  typedef struct packed {
    logic [10:0]          width;
    logic [10:0]          height;
    logic [1:0]           radius;
    logic [COEF_BITS-1:0] coefs;
  } rcmm_cfg_t;

  typedef struct packed {
    logic load;
    logic geom;
    logic write;
    logic tap_step;
    logic norm;
    logic div_step;
    logic emit;
  } rcmm_cmd_t;

  typedef struct packed {
    logic frame_start;
    logic need_out;
    logic taps_last;
    logic div_last;
    logic out_busy;
  } rcmm_status_t;

endpackage
`default_nettype wire

/* design/rcmm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module rcmm_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4101
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

/* design/rcmm_ctrl.sv */
// Sequencer for one item: load, geometry latch, store, tap walk, normalize, divide, emit.
`default_nettype none
module rcmm_ctrl
  import rcmm_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  input  wire rcmm_status_t status_i,
  output rcmm_cmd_t         cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_GEOM, S_WRITE, S_TAPS, S_DRAIN, S_NORM, S_DIV, S_EMIT
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = status_i.frame_start ? S_GEOM : S_WRITE;
        end
      end
      S_GEOM: begin
        cmd_o.geom = 1'b1;
        state_d    = S_WRITE;
      end
      S_WRITE: begin
        cmd_o.write = 1'b1;
        state_d     = status_i.need_out ? S_TAPS : S_IDLE;
      end
      S_TAPS: begin
        cmd_o.tap_step = 1'b1;
        if (status_i.taps_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: state_d = S_NORM;
      S_NORM: begin
        cmd_o.norm = 1'b1;
        state_d    = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!status_i.out_busy) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

/* design/rcmm_dp.sv */
// Datapath: position counters, line history, tap accumulators, divider and output register.
`default_nettype none
module rcmm_dp
  import rcmm_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire rcmm_cfg_t    cfg_i,
  input  wire rcmm_cmd_t    cmd_i,
  output rcmm_status_t      status_o,
  input  wire logic [23:0]  in_data_i,
  input  wire logic         in_kind_i,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  output logic [23:0]       out_data_o,
  output logic              out_last_o,
  output logic              out_zero_o
);

  localparam int REFF  = (MAX_RADIUS < 2) ? MAX_RADIUS : 2;
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int PW    = $clog2(MAX_WIDTH * MAX_HEIGHT + 2 * REFF * MAX_WIDTH + 2 * REFF + 2);
  localparam int DEPTH = 2 * (REFF * MAX_WIDTH + REFF) + 1;
  localparam int AW    = $clog2(DEPTH);
  localparam int SW    = 22;
  localparam int NW    = 21;

  // item and geometry
  logic          kind_q;
  logic [23:0]   px_q;
  logic [WW-1:0] cur_w_q, w_sat;
  logic [HW-1:0] cur_h_q, h_sat;
  logic [1:0]    cur_r_q, r_sat;
  logic [PW-1:0] total_q, delay_q;

  // position state
  logic [PW-1:0] in_pos_q;
  logic [AW-1:0] wr_ptr_q;
  logic [WW-1:0] out_col_q;
  logic [HW-1:0] out_row_q;
  logic          last_q;

  // tap walk
  logic [2:0]    dxi_q, dyi_q, two_r, k_sz;
  logic [AW-1:0] off_q, row_off_q;
  logic [AW:0]   rd_sum;
  logic [AW-1:0] raddr;
  logic [23:0]   rdata;
  logic [WW:0]   x_pos;
  logic [HW:0]   y_pos;
  logic          tap_hit;
  logic [4:0]    cidx;
  logic          p_valid_q, p_in_q;
  logic [7:0]    p_coef_q, p_mag;

  // arithmetic
  logic signed [SW-1:0] sum_q [3];
  logic signed [16:0]   prod [3];
  logic [11:0]          neg_q, pos_q;
  logic [12:0]          den_q;
  logic signed [23:0]   adj, num [3];
  logic [NW-1:0]        rem_q [3];
  logic [8:0]           quo_q [3];
  logic [3:0]           cnt_q;
  logic [NW-1:0]        dsh;

  logic [23:0]   out_data_q;
  logic          out_valid_q, out_last_q, out_zero_q;
  logic [7:0]    chan [3];

  always_comb begin
    if (cfg_i.width == 11'd0) w_sat = WW'(1);
    else if (32'(cfg_i.width) > MAX_WIDTH) w_sat = WW'(MAX_WIDTH);
    else w_sat = WW'(cfg_i.width);
    if (cfg_i.height == 11'd0) h_sat = HW'(1);
    else if (32'(cfg_i.height) > MAX_HEIGHT) h_sat = HW'(MAX_HEIGHT);
    else h_sat = HW'(cfg_i.height);
    if (32'(cfg_i.radius) > REFF) r_sat = 2'(REFF);
    else r_sat = cfg_i.radius;
  end

  assign two_r = {cur_r_q, 1'b0};
  assign k_sz  = two_r + 3'd1;

  assign status_o.frame_start = (in_pos_q == '0);
  assign status_o.need_out    = (in_pos_q >= delay_q);
  assign status_o.taps_last   = (dxi_q == two_r) && (dyi_q == two_r);
  assign status_o.div_last    = (cnt_q == 4'd0);
  assign status_o.out_busy    = out_valid_q && !out_ready_i;

  // ring address of the current tap: offset back from the newest stored pixel
  assign rd_sum = {1'b0, wr_ptr_q} + (AW + 1)'(DEPTH - 1) - {1'b0, off_q};
  assign raddr  = (rd_sum >= (AW + 1)'(DEPTH)) ? AW'(rd_sum - (AW + 1)'(DEPTH)) : AW'(rd_sum);

  assign x_pos   = {1'b0, out_col_q} + (WW + 1)'(dxi_q);
  assign y_pos   = {1'b0, out_row_q} + (HW + 1)'(dyi_q);
  assign tap_hit = (x_pos >= (WW + 1)'(cur_r_q)) && (x_pos < {1'b0, cur_w_q} + (WW + 1)'(cur_r_q))
                && (y_pos >= (HW + 1)'(cur_r_q)) && (y_pos < {1'b0, cur_h_q} + (HW + 1)'(cur_r_q));
  assign cidx    = 5'(dxi_q) * 5'(k_sz) + 5'(dyi_q);

  rcmm_ram #(.WIDTH(24), .DEPTH(DEPTH)) u_ring (
    .clk_i   (clk_i),
    .we_i    (cmd_i.write && (in_pos_q < total_q)),
    .waddr_i (wr_ptr_q),
    .wdata_i (kind_q ? 24'd0 : px_q),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign p_mag = p_coef_q[7] ? (~p_coef_q + 8'd1) : p_coef_q;
  assign adj   = $signed({4'b0, neg_q, 8'b0}) - $signed({12'b0, neg_q});
  assign dsh   = NW'(den_q) << cnt_q;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      prod[c] = $signed({1'b0, rdata[8*c +: 8]}) * $signed(p_coef_q);
      num[c]  = 24'(sum_q[c]) + adj;
      if (den_q == 13'd0) chan[c] = 8'd0;
      else if (quo_q[c][8]) chan[c] = 8'hFF;
      else chan[c] = quo_q[c][7:0];
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_pos_q    <= '0;
      wr_ptr_q    <= '0;
      out_col_q   <= '0;
      out_row_q   <= '0;
      out_valid_q <= 1'b0;
      p_valid_q   <= 1'b0;
    end else begin
      p_valid_q <= cmd_i.tap_step;
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.write) begin
        in_pos_q <= in_pos_q + PW'(1);
        wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
      end
      if (cmd_i.emit) begin
        if (last_q) begin
          in_pos_q  <= '0;
          wr_ptr_q  <= '0;
          out_col_q <= '0;
          out_row_q <= '0;
        end else if (out_col_q + WW'(1) >= cur_w_q) begin
          out_col_q <= '0;
          out_row_q <= out_row_q + HW'(1);
        end else begin
          out_col_q <= out_col_q + WW'(1);
        end
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q <= in_kind_i;
      px_q   <= in_data_i;
    end
    if (cmd_i.geom) begin
      cur_w_q <= w_sat;
      cur_h_q <= h_sat;
      cur_r_q <= r_sat;
      total_q <= PW'(w_sat) * PW'(h_sat);
      delay_q <= PW'((r_sat[1] ? {w_sat, 1'b0} : (r_sat[0] ? {1'b0, w_sat} : '0)))
               + PW'(r_sat);
    end
    if (cmd_i.write) begin
      last_q    <= ({1'b0, in_pos_q} + (PW + 1)'(1)) >= ({1'b0, total_q} + {1'b0, delay_q});
      dxi_q     <= '0;
      dyi_q     <= '0;
      off_q     <= AW'({delay_q, 1'b0});
      row_off_q <= AW'({delay_q, 1'b0});
      neg_q     <= '0;
      pos_q     <= '0;
      for (int c = 0; c < 3; c++) sum_q[c] <= '0;
    end
    if (cmd_i.tap_step) begin
      p_in_q   <= tap_hit;
      p_coef_q <= cfg_i.coefs[8*cidx +: 8];
      if (dxi_q == two_r) begin
        dxi_q     <= '0;
        dyi_q     <= dyi_q + 3'd1;
        row_off_q <= row_off_q - AW'(cur_w_q);
        off_q     <= row_off_q - AW'(cur_w_q);
      end else begin
        dxi_q <= dxi_q + 3'd1;
        off_q <= off_q - AW'(1);
      end
    end
    if (p_valid_q) begin
      if (p_coef_q[7]) neg_q <= neg_q + 12'(p_mag);
      else pos_q <= pos_q + 12'(p_mag);
      if (p_in_q) begin
        for (int c = 0; c < 3; c++) sum_q[c] <= sum_q[c] + SW'(prod[c]);
      end
    end
    if (cmd_i.norm) begin
      den_q <= 13'(neg_q) + 13'(pos_q);
      cnt_q <= 4'd8;
      for (int c = 0; c < 3; c++) begin
        rem_q[c] <= num[c][23] ? '0 : NW'(num[c]);
        quo_q[c] <= '0;
      end
    end
    if (cmd_i.div_step) begin
      if (cnt_q != 4'd0) cnt_q <= cnt_q - 4'd1;
      for (int c = 0; c < 3; c++) begin
        if (rem_q[c] >= dsh) begin
          rem_q[c]        <= rem_q[c] - dsh;
          quo_q[c][cnt_q] <= 1'b1;
        end
      end
    end
    if (cmd_i.emit) begin
      out_data_q <= {chan[2], chan[1], chan[0]};
      out_last_q <= last_q;
      out_zero_q <= (den_q == 13'd0);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_last_o  = out_last_q;
  assign out_zero_o  = out_zero_q;

endmodule
`default_nettype wire

/* design/rgb_convolution_min_max_normalize.sv */
// Top level of the zero-padded RGB convolution with min/max normalization.
//
// Pixels enter in raster order on the s_axis channel (tuser = kind: pixel or
// pad). Each color channel is convolved with a (2R+1)^2 kernel, pixels outside
// the image count as zero, and each sum S is normalized to
// floor((S + 255*NEG) / (POS + NEG)). One result leaves on m_axis per item once
// R*width+R items of the frame have gone in; tlast marks the frame's final
// result, tuser flags an all-zero kernel. Pad items flush the frame tail.
// Throughput: one item at a time. An item that yields no result is loaded and
// stored (the first item of a frame also latches geometry). An item that
// yields a result then walks its K*K taps (K = 2R+1), one tap per cycle
// through the single read port of the line history RAM, then runs a 9-step
// restoring divider on the three channels in parallel with a common divisor.
// The output register holds a finished result while the receiver stalls; the
// next item is still accepted, and the sequencer waits only when a second
// result is ready before the first is taken.
// Reset returns the position counters to the start of a frame and loads the
// register defaults (640 x 480, radius 1, all coefficients zero). The line
// history RAM is not cleared: only stored pixels of the current frame are used.
// Configuration writes are taken at any time.
`default_nettype none
module rgb_convolution_min_max_normalize
  import rcmm_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration write channel
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [63:0] cfg_data_i,
  // input stream
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [23:0] s_axis_tdata_i,   // red_in, green_in, blue_in
  input  wire logic        s_axis_tuser_i,   // kind
  // output stream
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [23:0]      m_axis_tdata_o,   // red_out, green_out, blue_out
  output logic             m_axis_tlast_o,   // frame_last
  output logic             m_axis_tuser_o    // zero_divisor
);

  rcmm_cfg_t    cfg_q;
  rcmm_cmd_t    cmd;
  rcmm_status_t status;

  assign cfg_ready_o = 1'b1;

  // hold the register file; a write to an unused index is dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width  <= 11'd640;
      cfg_q.height <= 11'd480;
      cfg_q.radius <= 2'd1;
      cfg_q.coefs  <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_WIDTH:  cfg_q.width          <= cfg_data_i[10:0];
        CFG_HEIGHT: cfg_q.height         <= cfg_data_i[10:0];
        CFG_RADIUS: cfg_q.radius         <= cfg_data_i[1:0];
        CFG_COEF0:  cfg_q.coefs[63:0]    <= cfg_data_i;
        CFG_COEF1:  cfg_q.coefs[127:64]  <= cfg_data_i;
        CFG_COEF2:  cfg_q.coefs[191:128] <= cfg_data_i;
        CFG_COEF3:  cfg_q.coefs[199:192] <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  rcmm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  rcmm_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_data_i   (s_axis_tdata_i),
    .in_kind_i   (s_axis_tuser_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o),
    .out_last_o  (m_axis_tlast_o),
    .out_zero_o  (m_axis_tuser_o)
  );

endmodule
`default_nettype wire
